>>> design/hps_pkg.sv
`timescale 1ns / 1ps

package hps_pkg;

    // Default table depth
    localparam int MAX_STEPS_DEF = 16;

    // Item function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;
    localparam logic [1:0] FUNC_STOP  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_GAIN        = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_HIGH = 2'd1;
    localparam logic [1:0] CFG_ENABLED     = 2'd2;

    // Configuration reset values
    localparam logic [7:0] GAIN_RESET = 8'd255;

    // Idle drive levels
    localparam logic [7:0] DUTY_IDLE_HIGH = 8'd0;
    localparam logic [7:0] DUTY_IDLE_LOW  = 8'd255;

    // One step table entry
    typedef struct packed {
        logic [15:0] dur;
        logic [7:0]  lvl;
    } hps_entry_t;

    // Result of one item
    typedef struct packed {
        logic [7:0] duty;
        logic       playing;
        logic       accepted;
    } hps_result_t;

    // Drive duty: (level*gain+127)/255, inverted for active low, idle when stopped.
    // x/255 for x < 65535 is (x + (x >> 8) + 1) >> 8.
    function automatic logic [7:0] drive_duty(
        input logic [7:0] level,
        input logic [7:0] gain,
        input logic       active_high,
        input logic       playing
    );
        logic [15:0] prod;
        logic [16:0] x;
        logic [16:0] q;
        logic [7:0]  scaled;
        prod   = 16'(level * gain);
        x      = 17'(prod) + 17'd127;
        q      = (x + (x >> 8) + 17'd1) >> 8;
        scaled = q[7:0];
        if (!playing)
        begin
            drive_duty = active_high ? DUTY_IDLE_HIGH : DUTY_IDLE_LOW;
        end
        else
        begin
            drive_duty = active_high ? scaled : (8'd255 - scaled);
        end
    endfunction

endpackage

>>> design/hps_step_table.sv
`timescale 1ns / 1ps

module hps_step_table #(
    parameter int MAX_STEPS = hps_pkg::MAX_STEPS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         wr_en,
    input  logic [((MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1)-1:0] wr_addr,
    input  hps_pkg::hps_entry_t                          wr_entry,
    input  logic [((MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1)-1:0] rd_addr,
    output logic [MAX_STEPS-1:0]                         entry_valid,
    output hps_pkg::hps_entry_t                          entry0,
    output hps_pkg::hps_entry_t                          prefetch
);

    localparam int POS_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    hps_pkg::hps_entry_t   mem [MAX_STEPS];
    hps_pkg::hps_entry_t   entry0_reg;
    hps_pkg::hps_entry_t   prefetch_reg;
    logic [MAX_STEPS-1:0]  valid_reg;
    logic [POS_W-1:0]      zero_addr;

    assign zero_addr = '0;

    // Table memory: one write port, one registered read port for the next step
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        prefetch_reg <= mem[rd_addr];
    end

    // Copy of entry 0, so a start can play the first step at once
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == zero_addr))
        begin
            entry0_reg <= wr_entry;
        end
    end

    // Written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign entry_valid = valid_reg;
    assign entry0      = entry0_reg;
    assign prefetch    = prefetch_reg;

endmodule

>>> design/hps_play_engine.sv
`timescale 1ns / 1ps

module hps_play_engine #(
    parameter int MAX_STEPS = hps_pkg::MAX_STEPS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         go,
    input  logic [1:0]                                   func,
    input  logic [3:0]                                   step_index,
    input  logic [15:0]                                  step_duration_ms,
    input  logic [4:0]                                   step_count,
    input  logic [15:0]                                  repeat_count,
    input  logic [7:0]                                   gain,
    input  logic                                         active_high,
    input  logic                                         enabled,
    input  logic                                         cfg_halt,
    input  logic [MAX_STEPS-1:0]                         entry_valid,
    input  hps_pkg::hps_entry_t                          entry0,
    input  hps_pkg::hps_entry_t                          prefetch,
    output logic                                         wr_en,
    output logic [((MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1)-1:0] rd_addr,
    output hps_pkg::hps_result_t                         res
);

    localparam int POS_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    logic              playing_reg, playing_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic [15:0]       repeats_reg, repeats_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       ms_reg, ms_next;
    logic [7:0]        level_reg, level_next;
    logic [15:0]       cur_dur_reg, cur_dur_next;

    logic [15:0]       ms_inc;
    logic [CNT_W-1:0]  pos_inc;
    logic [CNT_W-1:0]  nxt_inc;
    logic [MAX_STEPS-1:0] need;
    logic [31:0]       count_ext;
    logic              write_ok;
    logic              start_ok;
    logic              ok;

    // Write and start checks: a start needs every used entry to have been written
    always_comb
    begin
        count_ext = 32'(step_count);
        for (int i = 0; i < MAX_STEPS; i++)
        begin
            need[i] = (i < int'(step_count));
        end
        write_ok = !playing_reg && (step_duration_ms != 16'd0)
                   && (32'(step_index) < MAX_STEPS);
        start_ok = enabled && (step_count != 5'd0) && (count_ext <= MAX_STEPS)
                   && (repeat_count != 16'd0) && (&(entry_valid | ~need));
    end

    // Next playback state
    always_comb
    begin
        playing_next = playing_reg;
        active_next  = active_reg;
        repeats_next = repeats_reg;
        pos_next     = pos_reg;
        ms_next      = ms_reg;
        level_next   = level_reg;
        cur_dur_next = cur_dur_reg;
        ok           = 1'b1;
        wr_en        = 1'b0;
        ms_inc       = ms_reg + 16'd1;
        pos_inc      = CNT_W'(pos_reg) + CNT_W'(1);

        if (go)
        begin
            case (func)
                hps_pkg::FUNC_TICK:
                begin
                    if (playing_reg)
                    begin
                        if (ms_inc < cur_dur_reg)
                        begin
                            ms_next = ms_inc;
                        end
                        else
                        begin
                            ms_next = 16'd0;
                            if (pos_inc >= active_reg)
                            begin
                                // pattern wraps; last repeat ends playback
                                pos_next     = '0;
                                repeats_next = repeats_reg - 16'd1;
                                if (repeats_reg == 16'd1)
                                begin
                                    playing_next = 1'b0;
                                    level_next   = 8'd0;
                                end
                                else
                                begin
                                    level_next   = prefetch.lvl;
                                    cur_dur_next = prefetch.dur;
                                end
                            end
                            else
                            begin
                                pos_next     = pos_inc[POS_W-1:0];
                                level_next   = prefetch.lvl;
                                cur_dur_next = prefetch.dur;
                            end
                        end
                    end
                end
                hps_pkg::FUNC_WRITE:
                begin
                    ok    = write_ok;
                    wr_en = write_ok;
                end
                hps_pkg::FUNC_START:
                begin
                    ok = start_ok;
                    if (start_ok)
                    begin
                        active_next  = count_ext[CNT_W-1:0];
                        repeats_next = repeat_count;
                        pos_next     = '0;
                        ms_next      = 16'd0;
                        playing_next = 1'b1;
                        level_next   = entry0.lvl;
                        cur_dur_next = entry0.dur;
                    end
                end
                default:
                begin
                    // stop
                    playing_next = 1'b0;
                    level_next   = 8'd0;
                    ms_next      = 16'd0;
                    pos_next     = '0;
                    repeats_next = 16'd0;
                end
            endcase
        end

        // Disabling the block ends playback
        if (cfg_halt)
        begin
            playing_next = 1'b0;
            level_next   = 8'd0;
            ms_next      = 16'd0;
            pos_next     = '0;
            repeats_next = 16'd0;
        end

        // Fetch address of the step after the one now playing
        nxt_inc = CNT_W'(pos_next) + CNT_W'(1);
        rd_addr = (nxt_inc >= active_next) ? '0 : nxt_inc[POS_W-1:0];

        res.duty     = hps_pkg::drive_duty(level_next, gain, active_high, playing_next);
        res.playing  = playing_next;
        res.accepted = ok;
    end

    // Playback state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= 1'b0;
            active_reg  <= '0;
            repeats_reg <= 16'd0;
            pos_reg     <= '0;
            ms_reg      <= 16'd0;
            level_reg   <= 8'd0;
            cur_dur_reg <= 16'd0;
        end
        else
        begin
            playing_reg <= playing_next;
            active_reg  <= active_next;
            repeats_reg <= repeats_next;
            pos_reg     <= pos_next;
            ms_reg      <= ms_next;
            level_reg   <= level_next;
            cur_dur_reg <= cur_dur_next;
        end
    end

endmodule

>>> design/haptic_pattern_sequencer_unit.sv
`timescale 1ns / 1ps

// Haptic pattern sequencer: takes one item per clock (tick, step write, start, stop)
// and returns one result per item (PWM duty, playing flag, accepted flag). An accepted
// item sits in the input register and is executed once the output register is empty
// or being drained. Its result is then loaded into the output register, which raises
// out_valid until the result is taken.
// While the output register holds a result that is not taken, the item waits in the
// input register and in_ready stays low. The sustained rate is one item per cycle
// while out_ready is high.
// The playback state is updated once per item; the step table is a
// memory with one registered read port that always prefetches the step after the
// current one, plus a register copy of entry 0 used when a start begins playing.
// The user must write configuration only while no item is in flight; not enforced here.
module haptic_pattern_sequencer_unit #(
    parameter int MAX_STEPS = hps_pkg::MAX_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  step_index,
    input  logic [15:0] step_duration_ms,
    input  logic [7:0]  step_level,
    input  logic [4:0]  step_count,
    input  logic [15:0] repeat_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pwm_duty,
    output logic        playing,
    output logic        accepted
);

    localparam int POS_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    // Configuration registers
    logic [7:0] gain_reg;
    logic       active_high_reg;
    logic       enabled_reg;
    logic       cfg_halt;

    // Input register
    logic        in_vld_reg;
    logic [1:0]  func_reg;
    logic [3:0]  step_index_reg;
    logic [15:0] step_dur_reg;
    logic [7:0]  step_level_reg;
    logic [4:0]  step_count_reg;
    logic [15:0] repeat_count_reg;

    // Output register
    logic                 out_vld_reg;
    hps_pkg::hps_result_t res_reg;

    logic                 go;
    logic                 wr_en;
    logic [POS_W-1:0]     wr_addr;
    logic [POS_W-1:0]     rd_addr;
    logic [31:0]          index_ext;
    logic [MAX_STEPS-1:0] entry_valid;
    hps_pkg::hps_entry_t  wr_entry;
    hps_pkg::hps_entry_t  entry0;
    hps_pkg::hps_entry_t  prefetch;
    hps_pkg::hps_result_t res;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= hps_pkg::GAIN_RESET;
            active_high_reg <= 1'b1;
            enabled_reg     <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hps_pkg::CFG_GAIN:        gain_reg        <= cfg_wr_data;
                hps_pkg::CFG_ACTIVE_HIGH: active_high_reg <= cfg_wr_data[0];
                hps_pkg::CFG_ENABLED:     enabled_reg     <= cfg_wr_data[0];
                default:                  ;
            endcase
        end
    end

    assign cfg_halt = cfg_wr_en && (cfg_index == hps_pkg::CFG_ENABLED) && !cfg_wr_data[0];

    // Handshake: execute when the output register is free or being drained
    assign go       = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || go;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg         <= func;
            step_index_reg   <= step_index;
            step_dur_reg     <= step_duration_ms;
            step_level_reg   <= step_level;
            step_count_reg   <= step_count;
            repeat_count_reg <= repeat_count;
        end
    end

    // Step table write data
    assign index_ext    = 32'(step_index_reg);
    assign wr_addr      = index_ext[POS_W-1:0];
    assign wr_entry.dur = step_dur_reg;
    assign wr_entry.lvl = step_level_reg;

    hps_step_table #(
        .MAX_STEPS (MAX_STEPS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_entry    (wr_entry),
        .rd_addr     (rd_addr),
        .entry_valid (entry_valid),
        .entry0      (entry0),
        .prefetch    (prefetch)
    );

    hps_play_engine #(
        .MAX_STEPS (MAX_STEPS)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .go               (go),
        .func             (func_reg),
        .step_index       (step_index_reg),
        .step_duration_ms (step_dur_reg),
        .step_count       (step_count_reg),
        .repeat_count     (repeat_count_reg),
        .gain             (gain_reg),
        .active_high      (active_high_reg),
        .enabled          (enabled_reg),
        .cfg_halt         (cfg_halt),
        .entry_valid      (entry_valid),
        .entry0           (entry0),
        .prefetch         (prefetch),
        .wr_en            (wr_en),
        .rd_addr          (rd_addr),
        .res              (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (go)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign pwm_duty  = res_reg.duty;
    assign playing   = res_reg.playing;
    assign accepted  = res_reg.accepted;

    // A stopped motor always shows one of the two idle levels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !playing |-> (pwm_duty == 8'd0) || (pwm_duty == 8'd255))
        else $error("idle duty is not an idle level");

    // An accepted start shows up as playing in its result
    assert property (@(posedge clk) disable iff (!rst_n)
        go && (func_reg == hps_pkg::FUNC_START) && res.accepted |=> out_valid && playing)
        else $error("accepted start did not begin playback");

    // A step write with zero duration is refused
    assert property (@(posedge clk) disable iff (!rst_n)
        go && (func_reg == hps_pkg::FUNC_WRITE) && (step_dur_reg == 16'd0) |-> !wr_en)
        else $error("zero-duration step write reached the table");

endmodule

>>> tb/sv/haptic_drive_checker.sv
`timescale 1ns / 1ps

module haptic_drive_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  step_index,
    input  logic [15:0] step_duration_ms,
    input  logic [7:0]  step_level,
    input  logic [4:0]  step_count,
    input  logic [15:0] repeat_count,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  pwm_duty,
    input  logic        playing,
    input  logic        accepted,
    output int          fail_count,
    output int          pending
);

    import hps_pkg::*;

    localparam int STEPS = MAX_STEPS_DEF;

    // Shadow copy of the pattern table and playback state
    logic [15:0] pat_dur [STEPS];
    logic [7:0]  pat_lvl [STEPS];
    logic [STEPS-1:0] pat_written;
    logic [4:0]  play_steps;
    logic [15:0] plays_left;
    logic [4:0]  play_pos;
    logic [15:0] play_ms;
    logic        play_on;
    logic [7:0]  play_lvl;

    // Shadow configuration
    logic [7:0]  set_gain;
    logic        set_high;
    logic        set_en;

    // Expected drive results, oldest first
    hps_result_t expected_drive [$];

    function automatic void halt_play();
        play_on    = 1'b0;
        play_lvl   = 8'd0;
        play_ms    = 16'd0;
        play_pos   = 5'd0;
        plays_left = 16'd0;
    endfunction

    function automatic void reset_shadow();
        pat_written = '0;
        play_steps  = 5'd0;
        halt_play();
        set_gain    = GAIN_RESET;
        set_high    = 1'b1;
        set_en      = 1'b1;
    endfunction

    function automatic void apply_setting(logic [1:0] idx, logic [7:0] value);
        case (idx)
            CFG_GAIN:        set_gain = value;
            CFG_ACTIVE_HIGH: set_high = value[0];
            CFG_ENABLED:
            begin
                set_en = value[0];
                // disabling cuts playback at once
                if (!set_en)
                    halt_play();
            end
            default: ;
        endcase
    endfunction

    // Advance the shadow state by one item and return the drive it leaves behind
    function automatic hps_result_t sequence_item(
        logic [1:0]  f,
        logic [3:0]  idx,
        logic [15:0] dur,
        logic [7:0]  lvl,
        logic [4:0]  cnt,
        logic [15:0] reps
    );
        logic        ok;
        int          scaled;
        hps_result_t res;
        ok = 1'b1;
        case (f)
            FUNC_TICK:
            begin
                if (play_on)
                begin
                    play_ms = play_ms + 16'd1;
                    if (play_ms >= pat_dur[play_pos[3:0]])
                    begin
                        play_ms  = 16'd0;
                        play_pos = play_pos + 5'd1;
                        // end of pattern: wrap and count down the plays
                        if (play_pos >= play_steps)
                        begin
                            play_pos   = 5'd0;
                            plays_left = plays_left - 16'd1;
                            if (plays_left == 16'd0)
                                halt_play();
                        end
                        if (play_on)
                            play_lvl = pat_lvl[play_pos[3:0]];
                    end
                end
            end
            FUNC_WRITE:
            begin
                if (play_on || dur == 16'd0)
                    ok = 1'b0;
                else
                begin
                    pat_dur[idx]     = dur;
                    pat_lvl[idx]     = lvl;
                    pat_written[idx] = 1'b1;
                end
            end
            FUNC_START:
            begin
                if (!set_en || cnt == 5'd0 || cnt > STEPS || reps == 16'd0)
                    ok = 1'b0;
                else
                    for (int i = 0; i < cnt; i++)
                        if (!pat_written[i])
                            ok = 1'b0;
                if (ok)
                begin
                    play_steps = cnt;
                    plays_left = reps;
                    play_pos   = 5'd0;
                    play_ms    = 16'd0;
                    play_on    = 1'b1;
                    play_lvl   = pat_lvl[0];
                end
            end
            default: halt_play();
        endcase

        // motor drive for the state after this item
        if (!play_on)
            res.duty = set_high ? DUTY_IDLE_HIGH : DUTY_IDLE_LOW;
        else
        begin
            scaled   = (int'(play_lvl) * int'(set_gain) + 127) / 255;
            res.duty = set_high ? 8'(scaled) : 8'(255 - scaled);
        end
        res.playing  = play_on;
        res.accepted = ok;
        return res;
    endfunction

    function automatic void note_mismatch(string field, int want, int got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
    endfunction

    // Track config writes, score results, predict accepted items
    always @(posedge clk or negedge rst_n)
    begin
        hps_result_t want;
        if (!rst_n)
        begin
            reset_shadow();
            expected_drive.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                apply_setting(cfg_index, cfg_wr_data);

            if (out_valid && out_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] result with no item outstanding: duty %0d", $realtime,
                                 pwm_duty);
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (pwm_duty !== want.duty)
                        note_mismatch("pwm_duty", want.duty, pwm_duty);
                    if (playing !== want.playing)
                        note_mismatch("playing", want.playing, playing);
                    if (accepted !== want.accepted)
                        note_mismatch("accepted", want.accepted, accepted);
                end
            end

            if (in_valid && in_ready)
                expected_drive.push_back(sequence_item(func, step_index, step_duration_ms,
                                                       step_level, step_count, repeat_count));

            pending <= expected_drive.size();
        end
    end

endmodule

>>> tb/sv/tb_haptic_pattern_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_haptic_pattern_sequencer_unit;

    import hps_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         SEG_ITEMS    = 255;
    localparam logic [1:0] CFG_SPARE    = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_GAIN;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_TICK;
    logic [3:0]  step_index = 4'd0;
    logic [15:0] step_duration_ms = 16'd0;
    logic [7:0]  step_level = 8'd0;
    logic [4:0]  step_count = 5'd0;
    logic [15:0] repeat_count = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pwm_duty;
    logic        playing;
    logic        accepted;

    int fail_count;
    int pending;
    int send_idle = 37;
    int recv_idle = 75;
    int cycle_count = 0;

    haptic_pattern_sequencer_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .step_index       (step_index),
        .step_duration_ms (step_duration_ms),
        .step_level       (step_level),
        .step_count       (step_count),
        .repeat_count     (repeat_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pwm_duty         (pwm_duty),
        .playing          (playing),
        .accepted         (accepted)
    );

    haptic_drive_checker i_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .step_index       (step_index),
        .step_duration_ms (step_duration_ms),
        .step_level       (step_level),
        .step_count       (step_count),
        .repeat_count     (repeat_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pwm_duty         (pwm_duty),
        .playing          (playing),
        .accepted         (accepted),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // 100 MHz clock
    always #5 clk = ~clk;

    // Result side back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one item and hold it until accepted
    task automatic send_item(
        input logic [1:0]  f,
        input logic [3:0]  idx,
        input logic [15:0] dur,
        input logic [7:0]  lvl,
        input logic [4:0]  cnt,
        input logic [15:0] reps
    );
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        func             <= f;
        step_index       <= idx;
        step_duration_ms <= dur;
        step_level       <= lvl;
        step_count       <= cnt;
        repeat_count     <= reps;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every outstanding result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program all three registers, one per cycle
    task automatic set_regs(input logic [7:0] g, input logic hi, input logic en);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_GAIN;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_index   <= CFG_ACTIVE_HIGH;
        cfg_wr_data <= {7'd0, hi};
        @(posedge clk);
        cfg_index   <= CFG_ENABLED;
        cfg_wr_data <= {7'd0, en};
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly ticks with short steps and few plays, so patterns start, run and end often
    task automatic random_item();
        int          pick;
        logic [1:0]  f;
        logic [3:0]  idx;
        logic [15:0] dur;
        logic [7:0]  lvl;
        logic [4:0]  cnt;
        logic [15:0] reps;
        idx  = 4'($urandom);
        dur  = 16'($urandom);
        lvl  = 8'($urandom);
        cnt  = 5'($urandom);
        reps = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 58)
            f = FUNC_TICK;
        else if (pick < 76)
        begin
            f = FUNC_WRITE;
            if ($urandom_range(99) < 70)
                idx = 4'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 78)
                dur = 16'($urandom_range(1, 4));
            else if (pick < 88)
                dur = 16'd0;
        end
        else if (pick < 94)
        begin
            f = FUNC_START;
            pick = $urandom_range(99);
            if (pick < 70)
                cnt = 5'($urandom_range(1, 4));
            else if (pick < 85)
                cnt = 5'($urandom_range(1, 16));
            pick = $urandom_range(99);
            if (pick < 75)
                reps = 16'($urandom_range(1, 3));
            else if (pick < 85)
                reps = 16'd0;
        end
        else
            f = FUNC_STOP;
        send_item(f, idx, dur, lvl, cnt, reps);
    endtask

    task automatic random_run(input int n);
        repeat (n) random_item();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle cases, refused writes and starts, a full play-out
        send_item(FUNC_TICK,  4'd0,  16'd0,     8'd0,   5'd0,  16'd0);
        send_item(FUNC_STOP,  4'd0,  16'd0,     8'd0,   5'd0,  16'd0);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd1,  16'd1);
        send_item(FUNC_WRITE, 4'd0,  16'd0,     8'd255, 5'd0,  16'd0);
        send_item(FUNC_WRITE, 4'd0,  16'd2,     8'd255, 5'd0,  16'd0);
        send_item(FUNC_WRITE, 4'd1,  16'd1,     8'd0,   5'd0,  16'd0);
        send_item(FUNC_WRITE, 4'd15, 16'hFFFF,  8'd128, 5'd31, 16'hFFFF);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd0,  16'd1);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd17, 16'd1);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd2,  16'd0);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd3,  16'd1);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd2,  16'd2);
        // write attempt while playing
        send_item(FUNC_WRITE, 4'd2,  16'd3,     8'd77,  5'd0,  16'd0);
        // two passes of the two-step pattern, then idle
        repeat (6)
            send_item(FUNC_TICK, 4'd0, 16'd0, 8'd0, 5'd0, 16'd0);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd31, 16'd1);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd1,  16'hFFFF);
        // refused start keeps the current pattern, accepted one replaces it
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd0,  16'd5);
        send_item(FUNC_START, 4'd0,  16'd0,     8'd0,   5'd2,  16'd1);
        send_item(FUNC_STOP,  4'd0,  16'd0,     8'd0,   5'd0,  16'd0);
        send_item(FUNC_TICK,  4'd0,  16'd0,     8'd0,   5'd0,  16'd0);
        drain();

        // Sender idles 37%, receiver 75%
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SPARE;
        cfg_wr_data <= 8'($urandom);
        @(posedge clk);
        set_regs(8'd0, 1'b0, 1'b1);
        random_run(SEG_ITEMS);
        drain();

        // Leave a long pattern running, then disable to cut it off
        send_item(FUNC_START, 4'd0, 16'd0, 8'd0, 5'd1, 16'hFFFF);
        drain();
        set_regs(8'd255, 1'b1, 1'b0);
        random_run(SEG_ITEMS);
        drain();

        // Sender idles 75%, receiver 37%
        send_idle = 75;
        recv_idle = 37;
        set_regs(8'($urandom), 1'b0, 1'b1);
        random_run(SEG_ITEMS);
        drain();
        set_regs(8'd1, 1'b1, 1'b1);
        random_run(SEG_ITEMS);
        drain();

        // No idling on either side
        send_idle = 0;
        recv_idle = 0;
        set_regs(8'($urandom), 1'b1, 1'b1);
        random_run(SEG_ITEMS);
        drain();
        set_regs(8'd255, 1'b0, 1'b1);
        random_run(SEG_ITEMS);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
design/hps_pkg.sv
design/hps_step_table.sv
design/hps_play_engine.sv
design/haptic_pattern_sequencer_unit.sv
tb/sv/haptic_drive_checker.sv
tb/sv/tb_haptic_pattern_sequencer_unit.sv
